### rtl/core/toeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_pkg
// Shared types and codes for the timestamp ordered event queue.
// ----------------------------------------------------------------------------
package toeq_pkg;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [1:0] KIND_INSERT   = 2'd1;
  localparam logic [1:0] KIND_REMOVE   = 2'd2;
  localparam logic [1:0] KIND_PEEK     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CMP,
    ST_INS_PLACE,
    ST_FRONT,
    ST_RESULT
  } state_t;

  // Memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Result status handed to the output register
  typedef struct packed {
    logic valid;
    logic nonempty;
    logic dropped;
  } res_ctl_t;

endpackage

### rtl/core/timestamp_ordered_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_event_queue_top
// Event calendar: stable sorted queue of (time, id) entries, earliest first.
// ----------------------------------------------------------------------------
//
//  channel | beat carries                                | handshake
//  --------+---------------------------------------------+--------------------
//  req     | kind, time_value, event_id, current_time    | req_valid/req_stall
//  rsp     | front_valid, front_time, front_id, dropped, | rsp_valid/rsp_stall
//          | entry_count                                 |
//
//  Remove, peek and a refused insert pass through DISPATCH, FRONT and RESULT;
//  an insert first shifts each held entry with a strictly later time up one
//  slot in INS_CMP, then writes the new entry. This order is set by the
//  single read port of the entry memory: each shift step is one write and a
//  read of the entry below, if any, and the front entry is read back last.
//  Reset clears the count, head pointer and state; the entry memory is left
//  as it is, since only entries below the count are ever used.
//  A stalled response holds in the output register; the next request is
//  still taken and worked on, and waits only to load its own result.
//
module timestamp_ordered_event_queue_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 48,
  parameter int ID_BITS     = 16,
  localparam int AddrW      = $clog2(QUEUE_DEPTH),
  localparam int CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           kind,
  input  logic [TIME_BITS-1:0] time_value,
  input  logic [ID_BITS-1:0]   event_id,
  input  logic [TIME_BITS-1:0] current_time,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 front_valid,
  output logic [TIME_BITS-1:0] front_time,
  output logic [ID_BITS-1:0]   front_id,
  output logic                 dropped,
  output logic [CntW-1:0]      entry_count
);

  toeq_pkg::mem_ctl_t   mem_ctl;
  toeq_pkg::res_ctl_t   res;
  logic [AddrW-1:0]     wr_addr;
  logic [AddrW-1:0]     rd_addr;
  logic [TIME_BITS-1:0] wr_time;
  logic [ID_BITS-1:0]   wr_id;
  logic [TIME_BITS-1:0] rd_time;
  logic [ID_BITS-1:0]   rd_id;
  logic [CntW-1:0]      count;
  logic                 res_take;

  // Entry store: time in the upper bits, id in the lower
  toeq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (TIME_BITS + ID_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data ({wr_time, wr_id}),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data ({rd_time, rd_id})
  );

  toeq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .kind         (kind),
    .time_value   (time_value),
    .event_id     (event_id),
    .current_time (current_time),
    .mem_ctl      (mem_ctl),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .wr_time      (wr_time),
    .wr_id        (wr_id),
    .rd_time      (rd_time),
    .rd_id        (rd_id),
    .res          (res),
    .res_take     (res_take),
    .count        (count)
  );

  // Load a finished result once the output register is free or being drained
  assign res_take = res.valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Front fields read as zero on an empty queue
  always_ff @(posedge clk) begin
    if (res_take) begin
      front_valid <= res.nonempty;
      front_time  <= res.nonempty ? rd_time : '0;
      front_id    <= res.nonempty ? rd_id : '0;
      dropped     <= res.dropped;
      entry_count <= count;
    end
  end

endmodule

### rtl/core/toeq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module toeq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

### rtl/core/toeq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_ctrl
// Sequencer: circular sorted buffer in memory, insertion by backward shift.
// ----------------------------------------------------------------------------
module toeq_ctrl #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 48,
  parameter int ID_BITS     = 16,
  localparam int AddrW      = $clog2(QUEUE_DEPTH),
  localparam int CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            kind,
  input  logic [TIME_BITS-1:0]  time_value,
  input  logic [ID_BITS-1:0]    event_id,
  input  logic [TIME_BITS-1:0]  current_time,
  output toeq_pkg::mem_ctl_t    mem_ctl,
  output logic [AddrW-1:0]      wr_addr,
  output logic [AddrW-1:0]      rd_addr,
  output logic [TIME_BITS-1:0]  wr_time,
  output logic [ID_BITS-1:0]    wr_id,
  input  logic [TIME_BITS-1:0]  rd_time,
  input  logic [ID_BITS-1:0]    rd_id,
  output toeq_pkg::res_ctl_t    res,
  input  logic                  res_take,
  output logic [CntW-1:0]       count
);

  toeq_pkg::state_t state, state_next;

  logic [AddrW-1:0]     head;
  logic [CntW-1:0]      idx;
  logic [1:0]           op;
  logic [TIME_BITS-1:0] new_time;
  logic [ID_BITS-1:0]   new_id;
  logic                 dropped;
  logic                 wr_sel_new;
  logic [TIME_BITS:0]   sched_sum;
  logic [TIME_BITS-1:0] req_time;
  logic [CntW-1:0]      count_m1;
  logic [CntW-1:0]      idx_m1;
  logic [CntW-1:0]      idx_m2;
  logic                 full;
  logic                 move_up;

  function automatic logic [AddrW-1:0] wrap(input logic [AddrW-1:0] base,
                                            input logic [AddrW-1:0] off);
    logic [AddrW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AddrW+1)'(QUEUE_DEPTH)) begin
      s = s - (AddrW+1)'(QUEUE_DEPTH);
    end
    return s[AddrW-1:0];
  endfunction

  // Saturate the relative schedule at the largest time
  assign sched_sum = {1'b0, current_time} + {1'b0, time_value};
  assign req_time  = (kind == toeq_pkg::KIND_SCHEDULE)
                   ? (sched_sum[TIME_BITS] ? '1 : sched_sum[TIME_BITS-1:0])
                   : time_value;

  assign count_m1 = count - CntW'(1);
  assign idx_m1   = idx - CntW'(1);
  assign idx_m2   = idx - CntW'(2);
  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign move_up  = (new_time < rd_time);

  always_comb begin
    state_next = state;
    unique case (state)
      toeq_pkg::ST_IDLE: begin
        if (req_valid) state_next = toeq_pkg::ST_DISPATCH;
      end
      toeq_pkg::ST_DISPATCH: begin
        unique case (op)
          toeq_pkg::KIND_SCHEDULE, toeq_pkg::KIND_INSERT: begin
            if (full) state_next = toeq_pkg::ST_FRONT;
            else if (count == '0) state_next = toeq_pkg::ST_INS_PLACE;
            else state_next = toeq_pkg::ST_INS_CMP;
          end
          toeq_pkg::KIND_REMOVE, toeq_pkg::KIND_PEEK: begin
            state_next = toeq_pkg::ST_FRONT;
          end
        endcase
      end
      toeq_pkg::ST_INS_CMP: begin
        if (!move_up) state_next = toeq_pkg::ST_FRONT;
        else if (idx == CntW'(1)) state_next = toeq_pkg::ST_INS_PLACE;
      end
      toeq_pkg::ST_INS_PLACE: state_next = toeq_pkg::ST_FRONT;
      toeq_pkg::ST_FRONT:     state_next = toeq_pkg::ST_RESULT;
      toeq_pkg::ST_RESULT: begin
        if (res_take) state_next = toeq_pkg::ST_IDLE;
      end
      default: state_next = toeq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall     = 1'b1;
    mem_ctl       = '0;
    wr_addr       = wrap(head, idx[AddrW-1:0]);
    rd_addr       = head;
    wr_sel_new    = 1'b1;
    res           = '0;
    unique case (state)
      toeq_pkg::ST_IDLE: req_stall = 1'b0;
      toeq_pkg::ST_DISPATCH: begin
        // fetch the tail entry for the first comparison
        rd_addr       = wrap(head, count_m1[AddrW-1:0]);
        mem_ctl.rd_en = (op == toeq_pkg::KIND_SCHEDULE || op == toeq_pkg::KIND_INSERT)
                        && !full && (count != '0);
      end
      toeq_pkg::ST_INS_CMP: begin
        // shift the later entry up one slot and prefetch the one below it, or place the new entry
        mem_ctl.wr_en = 1'b1;
        wr_sel_new    = !move_up;
        rd_addr       = wrap(head, idx_m2[AddrW-1:0]);
        mem_ctl.rd_en = move_up && (idx != CntW'(1));
      end
      toeq_pkg::ST_INS_PLACE: mem_ctl.wr_en = 1'b1;
      toeq_pkg::ST_FRONT:     mem_ctl.rd_en = 1'b1;
      toeq_pkg::ST_RESULT: begin
        res.valid    = 1'b1;
        res.nonempty = (count != '0);
        res.dropped  = dropped;
      end
      default: ;
    endcase
  end

  assign wr_time = wr_sel_new ? new_time : rd_time;
  assign wr_id   = wr_sel_new ? new_id : rd_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= toeq_pkg::ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == toeq_pkg::ST_DISPATCH && op == toeq_pkg::KIND_REMOVE && count != '0) begin
        head  <= wrap(head, AddrW'(1));
        count <= count_m1;
      end
      if ((state == toeq_pkg::ST_INS_CMP && !move_up) || state == toeq_pkg::ST_INS_PLACE) begin
        count <= count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == toeq_pkg::ST_IDLE && req_valid) begin
      op       <= kind;
      new_time <= req_time;
      new_id   <= event_id;
      dropped  <= 1'b0;
    end
    if (state == toeq_pkg::ST_DISPATCH) begin
      idx <= count;
      if ((op == toeq_pkg::KIND_SCHEDULE || op == toeq_pkg::KIND_INSERT) && full) begin
        dropped <= 1'b1;
      end
    end
    if (state == toeq_pkg::ST_INS_CMP && move_up) begin
      idx <= idx_m1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en && mem_ctl.rd_en |-> wr_addr != rd_addr)
    else $error("read and write hit the same entry");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.dropped |-> full)
    else $error("insert refused while space remained");

  a_shift_idx: assert property (@(posedge clk) disable iff (rst)
    state == toeq_pkg::ST_INS_CMP |-> idx != '0)
    else $error("shift step with no entry below");

endmodule
